### design/bmsb_pkg.sv
// Shared constants, register indexes and helpers for the button mode selector.
package bmsb_pkg;

	localparam int NUM_MODES = 4;
	localparam int MODE_W    = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
	localparam int LED_W     = 4;
	localparam int CUR_W     = 2;
	localparam int HOLD_W    = 8;
	localparam int HALF_W    = 8;
	localparam int STEPS_W   = 4;
	localparam int SMODE_W   = 2;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [HOLD_W-1:0]  PRESS_HOLD_RST   = 8'd5;
	localparam logic [HOLD_W-1:0]  RELEASE_HOLD_RST = 8'd5;
	localparam logic [HALF_W-1:0]  HALF_PERIOD_RST  = 8'd25;
	localparam logic [STEPS_W-1:0] BLINK_STEPS_RST  = 4'd7;
	localparam logic [SMODE_W-1:0] START_MODE_RST   = 2'd0;

	typedef enum logic [2:0] {
		REG_PRESS_HOLD   = 3'd0,
		REG_RELEASE_HOLD = 3'd1,
		REG_HALF_PERIOD  = 3'd2,
		REG_BLINK_STEPS  = 3'd3,
		REG_START_MODE   = 3'd4
	} reg_idx_t;

	// LED bit of a mode; modes past the LED field fall off the top.
	function automatic logic [LED_W-1:0] one_hot(input logic [MODE_W-1:0] m);
		logic [15:0] w;
		w = 16'd1 << m;
		return w[LED_W-1:0];
	endfunction

	// Stored mode to load; out-of-range values select mode 0.
	function automatic logic [MODE_W-1:0] start_to_mode(input logic [SMODE_W-1:0] s);
		logic [MODE_W-1:0] m;
		if (32'(s) >= NUM_MODES) begin
			m = '0;
		end else begin
			m = MODE_W'(s);
		end
		return m;
	endfunction

endpackage

### design/button_mode_selector_with_blink_top.sv
// Top level of the button mode selector with blink sequence and commit pulse.
//
// Usage:
//   Input channel (in_valid/in_ready, payload button_pressed): one transfer per
//   tick of about 10 ms carrying the sampled button level, 1 = pressed.
//   Output channel (out_valid/out_ready, payload led_mask, current_mode,
//   commit): exactly one transfer per input transfer, in order.
//   APB port: five registers at byte addresses 0x00..0x10 (press hold, release
//   hold, blink half-period, blink steps, start mode). Write them only while no
//   tick is in flight. Writing start mode reloads selected and active mode,
//   relights that mode's LED and cancels any running blink sequence.
// Timing:
//   A tick is captured in the input register, the debounce and blink update
//   runs combinationally, and the result lands in the output register once
//   that register is empty or being drained. One tick per cycle sustained
//   while out_ready stays high; the single state update between the two
//   registers sets this rate.
// Reset:
//   arst_n clears both pipeline valids, loads register defaults (hold 5,
//   half-period 25, steps 7, start mode 0), selects mode 0 with its LED lit and
//   treats the button as released.
// Stall:
//   When out_ready is low the result holds in the output register; one more
//   tick may wait in the input register, after which in_ready drops.
module button_mode_selector_with_blink_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// input ticks
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             button_pressed,
	// results
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bmsb_pkg::LED_W-1:0]       led_mask,
	output logic [bmsb_pkg::CUR_W-1:0]       current_mode,
	output logic                             commit,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bmsb_pkg::ADDR_W-1:0]      paddr,
	input  logic [bmsb_pkg::DATA_W-1:0]      pwdata,
	output logic [bmsb_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	// configuration registers
	logic [bmsb_pkg::HOLD_W-1:0]  press_hold_q;
	logic [bmsb_pkg::HOLD_W-1:0]  release_hold_q;
	logic [bmsb_pkg::HALF_W-1:0]  half_period_q;
	logic [bmsb_pkg::STEPS_W-1:0] blink_steps_q;
	logic [bmsb_pkg::SMODE_W-1:0] start_mode_q;

	// block state
	logic [bmsb_pkg::MODE_W-1:0]  selected_mode_q;
	logic [bmsb_pkg::MODE_W-1:0]  active_mode_q;
	logic [bmsb_pkg::STEPS_W-1:0] blink_left_q;
	logic [bmsb_pkg::HALF_W-1:0]  half_left_q;
	logic                         button_held_q;
	logic [bmsb_pkg::HOLD_W-1:0]  debounce_count_q;
	logic [bmsb_pkg::LED_W-1:0]   led_state_q;

	// pipeline registers
	logic valid_s1;
	logic button_s1;
	logic out_valid_q;
	logic [bmsb_pkg::LED_W-1:0] led_mask_q;
	logic [bmsb_pkg::CUR_W-1:0] current_mode_q;
	logic commit_q;

	logic cfg_wr;
	bmsb_pkg::reg_idx_t cfg_idx;
	logic advance;
	logic [bmsb_pkg::MODE_W-1:0] load_mode;

	// next-state values
	logic                         press_d;
	logic                         held_d;
	logic [bmsb_pkg::HOLD_W-1:0]  count_d;
	logic [bmsb_pkg::MODE_W-1:0]  sel_d;
	logic [bmsb_pkg::MODE_W-1:0]  act_d;
	logic [bmsb_pkg::STEPS_W-1:0] blink_d;
	logic [bmsb_pkg::HALF_W-1:0]  half_d;
	logic [bmsb_pkg::LED_W-1:0]   led_d;
	logic                         commit_d;
	logic [bmsb_pkg::MODE_W:0]    sel_inc;
	logic [bmsb_pkg::HALF_W-1:0]  half_dec;
	logic [bmsb_pkg::STEPS_W-1:0] blink_dec;
	logic [bmsb_pkg::LED_W-1:0]   sel_bit;

	// APB: always ready, write on the access phase
	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign cfg_idx   = bmsb_pkg::reg_idx_t'(paddr[4:2]);
	assign load_mode = bmsb_pkg::start_to_mode(pwdata[bmsb_pkg::SMODE_W-1:0]);

	always_comb begin
		case (cfg_idx)
			bmsb_pkg::REG_PRESS_HOLD:   prdata = bmsb_pkg::DATA_W'(press_hold_q);
			bmsb_pkg::REG_RELEASE_HOLD: prdata = bmsb_pkg::DATA_W'(release_hold_q);
			bmsb_pkg::REG_HALF_PERIOD:  prdata = bmsb_pkg::DATA_W'(half_period_q);
			bmsb_pkg::REG_BLINK_STEPS:  prdata = bmsb_pkg::DATA_W'(blink_steps_q);
			bmsb_pkg::REG_START_MODE:   prdata = bmsb_pkg::DATA_W'(start_mode_q);
			default:                    prdata = '0;
		endcase
	end

	// Handshake: the input register moves on whenever the output register
	// is empty or being drained this cycle.
	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign out_valid = out_valid_q;
	assign led_mask     = led_mask_q;
	assign current_mode = current_mode_q;
	assign commit       = commit_q;

	// Debounce: separate hold counts for press and release; the counter clears
	// once it reaches the hold value instead of wrapping.
	always_comb begin
		press_d = 1'b0;
		held_d  = button_held_q;
		count_d = debounce_count_q;
		if (button_held_q) begin
			if (button_s1) begin
				count_d = '0;
			end else if (debounce_count_q >= release_hold_q) begin
				held_d  = 1'b0;
				count_d = '0;
			end else begin
				count_d = debounce_count_q + 1'b1;
			end
		end else if (!button_s1) begin
			count_d = '0;
		end else if (debounce_count_q >= press_hold_q) begin
			held_d  = 1'b1;
			count_d = '0;
			press_d = 1'b1;
		end else begin
			count_d = debounce_count_q + 1'b1;
		end
	end

	// Mode advance and blink sequence
	always_comb begin
		sel_inc   = {1'b0, selected_mode_q} + 1'b1;
		half_dec  = (half_left_q != '0) ? half_left_q - 1'b1 : half_left_q;
		blink_dec = blink_left_q - 1'b1;
		sel_bit   = bmsb_pkg::one_hot(selected_mode_q);
		sel_d     = selected_mode_q;
		act_d     = active_mode_q;
		blink_d   = blink_left_q;
		half_d    = half_left_q;
		led_d     = led_state_q;
		commit_d  = 1'b0;
		if (press_d) begin
			// advance the selection cyclically and restart the sequence
			if (32'(sel_inc) >= bmsb_pkg::NUM_MODES) begin
				sel_d = '0;
			end else begin
				sel_d = sel_inc[bmsb_pkg::MODE_W-1:0];
			end
			blink_d = blink_steps_q;
			half_d  = half_period_q;
			led_d   = bmsb_pkg::one_hot(sel_d);
		end else if (blink_left_q != '0) begin
			half_d = half_dec;
			if (half_dec == '0) begin
				blink_d = blink_dec;
				if (blink_dec != '0) begin
					// light the selected LED on odd steps left, clear it on even ones
					half_d = half_period_q;
					if (blink_dec[0]) begin
						led_d = led_state_q | sel_bit;
					end else begin
						led_d = led_state_q & ~sel_bit;
					end
				end else if (active_mode_q != selected_mode_q) begin
					// sequence over: activate the new selection
					act_d    = selected_mode_q;
					led_d    = led_state_q | sel_bit;
					commit_d = 1'b1;
				end
			end
		end
	end

	// configuration registers and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_hold_q     <= bmsb_pkg::PRESS_HOLD_RST;
			release_hold_q   <= bmsb_pkg::RELEASE_HOLD_RST;
			half_period_q    <= bmsb_pkg::HALF_PERIOD_RST;
			blink_steps_q    <= bmsb_pkg::BLINK_STEPS_RST;
			start_mode_q     <= bmsb_pkg::START_MODE_RST;
			selected_mode_q  <= bmsb_pkg::start_to_mode(bmsb_pkg::START_MODE_RST);
			active_mode_q    <= bmsb_pkg::start_to_mode(bmsb_pkg::START_MODE_RST);
			blink_left_q     <= '0;
			half_left_q      <= '0;
			button_held_q    <= 1'b0;
			debounce_count_q <= '0;
			led_state_q      <= bmsb_pkg::one_hot(
				bmsb_pkg::start_to_mode(bmsb_pkg::START_MODE_RST));
		end else if (cfg_wr) begin
			case (cfg_idx)
				bmsb_pkg::REG_PRESS_HOLD:   press_hold_q   <= pwdata[bmsb_pkg::HOLD_W-1:0];
				bmsb_pkg::REG_RELEASE_HOLD: release_hold_q <= pwdata[bmsb_pkg::HOLD_W-1:0];
				bmsb_pkg::REG_HALF_PERIOD:  half_period_q  <= pwdata[bmsb_pkg::HALF_W-1:0];
				bmsb_pkg::REG_BLINK_STEPS:  blink_steps_q  <= pwdata[bmsb_pkg::STEPS_W-1:0];
				bmsb_pkg::REG_START_MODE: begin
					// reload both modes, cancel blinking, keep debounce state
					start_mode_q    <= pwdata[bmsb_pkg::SMODE_W-1:0];
					selected_mode_q <= load_mode;
					active_mode_q   <= load_mode;
					blink_left_q    <= '0;
					half_left_q     <= '0;
					led_state_q     <= bmsb_pkg::one_hot(load_mode);
				end
				default: ;
			endcase
		end else if (advance) begin
			selected_mode_q  <= sel_d;
			active_mode_q    <= act_d;
			blink_left_q     <= blink_d;
			half_left_q      <= half_d;
			button_held_q    <= held_d;
			debounce_count_q <= count_d;
			led_state_q      <= led_d;
		end
	end

	// input register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			button_s1 <= button_pressed;
		end
	end

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: payload, taken from the updated state
	always_ff @(posedge clk) begin
		if (advance) begin
			led_mask_q     <= led_d;
			current_mode_q <= bmsb_pkg::CUR_W'(act_d);
			commit_q       <= commit_d;
		end
	end

	// a commit ends the sequence
	a_commit_ends_blink: assert property (@(posedge clk) disable iff (!arst_n)
		advance && commit_d |=> blink_left_q == '0)
		else $error("commit left a blink sequence running");

	// a commit makes the previous selection active
	a_commit_activates: assert property (@(posedge clk) disable iff (!arst_n)
		advance && commit_d |=> active_mode_q == $past(selected_mode_q))
		else $error("commit did not activate the selected mode");

	// with both registers full and the receiver stalled, take no new tick
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("input accepted while pipeline full and stalled");

endmodule

### tb/sv/tb_button_mode_selector_with_blink_top.sv
// Self-checking testbench for the button mode selector with blink sequence.
module tb_button_mode_selector_with_blink_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmsb_pkg::*;

	localparam int NUM_REGS       = 5;     // registers in the APB map
	localparam int STRAY_REG_IDX  = 5;     // first index past the register file
	localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
	localparam int DRAIN_CYCLES   = 8;     // margin after the drain for stray results
	localparam int HOLDOFF_CYCLES = 80;    // long receiver stall for the pressure test

	typedef struct packed {
		logic [LED_W-1:0] led_mask;
		logic [CUR_W-1:0] current_mode;
		logic             commit;
	} tick_result_t;

	// DUT ports; every input starts at a known value
	logic                clk;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic                button_pressed = 1'b0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [LED_W-1:0]    led_mask;
	logic [CUR_W-1:0]    current_mode;
	logic                commit;
	logic                psel           = 1'b0;
	logic                penable        = 1'b0;
	logic                pwrite         = 1'b0;
	logic [ADDR_W-1:0]   paddr          = '0;
	logic [DATA_W-1:0]   pwdata         = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// Register copy kept by the predictor
	logic [HOLD_W-1:0]   press_hold_cfg;
	logic [HOLD_W-1:0]   release_hold_cfg;
	logic [HALF_W-1:0]   half_period_cfg;
	logic [STEPS_W-1:0]  blink_steps_cfg;
	logic [SMODE_W-1:0]  start_mode_cfg;

	// Selector state kept by the predictor
	logic [MODE_W-1:0]   sel_mode;
	logic [MODE_W-1:0]   act_mode;
	logic [STEPS_W-1:0]  blinks_left;
	logic [HALF_W-1:0]   half_left;
	logic                btn_held;
	logic [HOLD_W-1:0]   deb_count;
	logic [LED_W-1:0]    led_lit;

	tick_result_t        pending_results[$];
	int                  errors         = 0;
	int                  send_idle_pct  = 0;
	int                  recv_idle_pct  = 0;
	int                  holdoff_req    = 0;
	int                  holdoff_left   = 0;
	int                  stall_cycles   = 0;

	button_mode_selector_with_blink_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.button_pressed (button_pressed),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.led_mask       (led_mask),
		.current_mode   (current_mode),
		.commit         (commit),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [LED_W-1:0] led_of(input logic [MODE_W-1:0] m);
		led_of = LED_W'(1) << m;
	endfunction

	// Reload both modes from the stored start mode and cancel any blinking.
	function automatic void load_start_mode();
		logic [MODE_W-1:0] m;
		if (int'(start_mode_cfg) >= NUM_MODES) begin
			m = '0;
		end else begin
			m = MODE_W'(start_mode_cfg);
		end
		sel_mode    = m;
		act_mode    = m;
		blinks_left = '0;
		half_left   = '0;
		led_lit     = led_of(m);
	endfunction

	function automatic void reset_selector();
		press_hold_cfg   = PRESS_HOLD_RST;
		release_hold_cfg = RELEASE_HOLD_RST;
		half_period_cfg  = HALF_PERIOD_RST;
		blink_steps_cfg  = BLINK_STEPS_RST;
		start_mode_cfg   = START_MODE_RST;
		btn_held         = 1'b0;
		deb_count        = '0;
		load_start_mode();
	endfunction

	// Mirror a register write; indexes past the map change nothing.
	function automatic void apply_reg(input int idx, input logic [DATA_W-1:0] value);
		case (idx)
			REG_PRESS_HOLD:   press_hold_cfg   = value[HOLD_W-1:0];
			REG_RELEASE_HOLD: release_hold_cfg = value[HOLD_W-1:0];
			REG_HALF_PERIOD:  half_period_cfg  = value[HALF_W-1:0];
			REG_BLINK_STEPS:  blink_steps_cfg  = value[STEPS_W-1:0];
			REG_START_MODE: begin
				start_mode_cfg = value[SMODE_W-1:0];
				load_start_mode();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(input int idx);
		case (idx)
			REG_PRESS_HOLD:   reg_value = DATA_W'(press_hold_cfg);
			REG_RELEASE_HOLD: reg_value = DATA_W'(release_hold_cfg);
			REG_HALF_PERIOD:  reg_value = DATA_W'(half_period_cfg);
			REG_BLINK_STEPS:  reg_value = DATA_W'(blink_steps_cfg);
			REG_START_MODE:   reg_value = DATA_W'(start_mode_cfg);
			default:          reg_value = '0;
		endcase
	endfunction

	// Advance the selector by one tick and return the result it shows.
	function automatic tick_result_t advance_selector(input logic level);
		tick_result_t r;
		logic         press_seen;
		press_seen = 1'b0;
		r.commit   = 1'b0;

		// debounce: the counter clears at the hold value, never wraps
		if (btn_held) begin
			if (level) begin
				deb_count = '0;
			end else if (deb_count >= release_hold_cfg) begin
				btn_held  = 1'b0;
				deb_count = '0;
			end else begin
				deb_count = deb_count + 1'b1;
			end
		end else if (!level) begin
			deb_count = '0;
		end else if (deb_count >= press_hold_cfg) begin
			btn_held   = 1'b1;
			deb_count  = '0;
			press_seen = 1'b1;
		end else begin
			deb_count = deb_count + 1'b1;
		end

		if (press_seen) begin
			// advance the selection and (re)start the blink sequence
			if (int'(sel_mode) + 1 >= NUM_MODES) begin
				sel_mode = '0;
			end else begin
				sel_mode = sel_mode + 1'b1;
			end
			blinks_left = blink_steps_cfg;
			half_left   = half_period_cfg;
			led_lit     = led_of(sel_mode);
		end else if (blinks_left != 0) begin
			if (half_left > 0) begin
				half_left = half_left - 1'b1;
			end
			if (half_left == 0) begin
				blinks_left = blinks_left - 1'b1;
				if (blinks_left > 0) begin
					half_left = half_period_cfg;
					if (blinks_left[0]) begin
						led_lit = led_lit | led_of(sel_mode);
					end else begin
						led_lit = led_lit & ~led_of(sel_mode);
					end
				end else if (act_mode != sel_mode) begin
					act_mode = sel_mode;
					led_lit  = led_lit | led_of(sel_mode);
					r.commit = 1'b1;
				end
			end
		end

		r.led_mask     = led_lit;
		r.current_mode = CUR_W'(act_mode);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Offer one tick, idling at random first; predict it once the transfer happens.
	task automatic send_tick(input logic level);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid       <= 1'b0;
			button_pressed <= 1'($urandom_range(1));
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		button_pressed <= level;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pending_results.push_back(advance_selector(level));
	endtask

	// Drop valid and hold until every predicted result has been seen.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// APB write followed by a read-back; only ever issued with the block idle.
	task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] readback;
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * idx);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		apply_reg(idx, value);
		// go straight into the read setup phase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx < NUM_REGS && readback !== reg_value(idx)) begin
			$error("register %0d read-back: expected %0h, actual %0h",
				idx, reg_value(idx), readback);
			errors++;
		end
		// one idle APB cycle before anything else is driven
		@(posedge clk);
	endtask

	task automatic set_timing(input int ph, input int rh, input int hp, input int st);
		write_reg(REG_PRESS_HOLD, DATA_W'(ph));
		write_reg(REG_RELEASE_HOLD, DATA_W'(rh));
		write_reg(REG_HALF_PERIOD, DATA_W'(hp));
		write_reg(REG_BLINK_STEPS, DATA_W'(st));
	endtask

	// Mostly clean presses with random hold and gap lengths, some bounce noise.
	task automatic play_random_ticks(input int count);
		int sent;
		int kind;
		int n_on;
		int n_off;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(9);
			if (kind < 7) begin
				n_on  = int'(press_hold_cfg) + 1 + $urandom_range(2);
				// short gaps press again mid-sequence, long ones let it commit
				n_off = int'(release_hold_cfg) + 1 +
					$urandom_range(int'(half_period_cfg) * int'(blink_steps_cfg) + 3);
				repeat (n_on) send_tick(1'b1);
				repeat (n_off) send_tick(1'b0);
				sent += n_on + n_off;
			end else begin
				n_on = $urandom_range(1, 4);
				repeat (n_on) send_tick(1'($urandom_range(1)));
				sent += n_on;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed_sequences();
		set_timing(0, 0, 1, 2);
		// press, one blink step, then the commit of mode 1
		send_tick(1'b1); send_tick(1'b0); send_tick(1'b0);
		// press again in the middle of a sequence: it restarts for the new selection
		send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
		send_tick(1'b0); send_tick(1'b0); send_tick(1'b0);
		// no blink steps: the selection moves but nothing commits
		write_reg(REG_BLINK_STEPS, DATA_W'(0));
		send_tick(1'b1); send_tick(1'b0); send_tick(1'b0);
		// zero half-period: every tick of the sequence is a blink step
		write_reg(REG_HALF_PERIOD, DATA_W'(0));
		write_reg(REG_BLINK_STEPS, DATA_W'(3));
		send_tick(1'b1); send_tick(1'b0); send_tick(1'b0); send_tick(1'b0);
		// start mode write cancels a running sequence and reloads both modes
		write_reg(REG_HALF_PERIOD, DATA_W'(3));
		write_reg(REG_BLINK_STEPS, DATA_W'(2));
		send_tick(1'b1);
		write_reg(REG_START_MODE, DATA_W'(3));
		send_tick(1'b0); send_tick(1'b0); send_tick(1'b0); send_tick(1'b0);
	endtask

	// Walk the timing registers to their top values and back down, write two start modes and poke an index past the map.
	task automatic test_register_map();
		set_timing(255, 255, 255, 15);
		set_timing(0, 0, 1, 1);
		write_reg(REG_START_MODE, DATA_W'(0));
		write_reg(REG_START_MODE, DATA_W'(2));
		write_reg(STRAY_REG_IDX, DATA_W'($urandom));
		send_tick(1'b0); send_tick(1'b1); send_tick(1'b0);
	endtask

	task automatic test_random_settings(input int n_settings, input int n_items);
		int st;
		repeat (n_settings) begin
			st = ($urandom_range(4) == 0) ? 15 : $urandom_range(0, 6);
			set_timing($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4), st);
			if ($urandom_range(1)) begin
				write_reg(REG_START_MODE, DATA_W'($urandom_range(0, 3)));
			end
			play_random_ticks(n_items);
		end
	endtask

	// Longest holds and half-period: a press needs 256 pressed ticks,
	// the single blink step 255 more, and the release 256 released ticks.
	task automatic test_long_holds();
		set_timing(255, 255, 255, 1);
		write_reg(REG_START_MODE, DATA_W'($urandom_range(0, 3)));
		repeat (256) send_tick(1'b1);
		repeat (260) send_tick(1'b0);
	endtask

	// Stall the receiver for a long stretch while ticks keep coming,
	// so the pipeline fills and in_ready drops.
	task automatic test_output_backpressure();
		set_timing(1, 1, 2, 3);
		holdoff_req = HOLDOFF_CYCLES;
		play_random_ticks(60);
	endtask

	// ------------------------------------------------------------------
	// Receiver, checker, watchdog
	// ------------------------------------------------------------------

	// Drive out_ready: random stalls, or a counted hold-off when one is requested.
	always @(posedge clk) begin
		if (holdoff_req > 0) begin
			holdoff_left = holdoff_req;
			holdoff_req  = 0;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin : check_results
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no tick pending: led_mask %0h current_mode %0d commit %0b",
					led_mask, current_mode, commit);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (led_mask !== want.led_mask) begin
					$error("led_mask: expected %0h, actual %0h", want.led_mask, led_mask);
					errors++;
				end
				if (current_mode !== want.current_mode) begin
					$error("current_mode: expected %0d, actual %0d",
						want.current_mode, current_mode);
					errors++;
				end
				if (commit !== want.commit) begin
					$error("commit: expected %0b, actual %0b", want.commit, commit);
					errors++;
				end
			end
		end
	end

	// End the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of tests
	// ------------------------------------------------------------------

	initial begin
		reset_selector();
		// hold reset low, then release it on a clock edge
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver mostly stalling
		send_idle_pct = 19;
		recv_idle_pct = 69;
		test_directed_sequences();
		test_register_map();
		test_random_settings(2, 30);

		// the other way round
		send_idle_pct = 69;
		recv_idle_pct = 19;
		test_random_settings(2, 30);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_long_holds();
		test_output_backpressure();

		// drain, then allow a few extra cycles for stray results
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
